// File: rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int CFG_WIDTH   = 16;
	localparam int IDX_WIDTH   = 2;

	localparam logic [IDX_WIDTH-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [IDX_WIDTH-1:0] REG_GAP      = 2'd1;
	localparam logic [IDX_WIDTH-1:0] REG_LONG     = 2'd2;

	localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_WIDTH-1:0] GAP_RST      = 16'd250;
	localparam logic [CFG_WIDTH-1:0] LONG_RST     = 16'd4000;

	typedef enum logic [1:0] {
		G_NONE   = 2'd0,
		G_SINGLE = 2'd1,
		G_DOUBLE = 2'd2,
		G_LONG   = 2'd3
	} gesture_t;

	typedef struct packed {
		gesture_t gesture;
		logic     stable_level;
	} result_t;

endpackage

// File: rtl/bcc_in.sv
// ----------------------------------------------------------------------------
// bcc_in
// Input register stage: holds one raw level item until the core takes it.
// ----------------------------------------------------------------------------
module bcc_in (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_level,
	input  logic take,
	output logic valid_s1,
	output logic level_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			level_s1 <= in_level;
		end
	end

endmodule

// File: rtl/bcc_core.sv
// ----------------------------------------------------------------------------
// bcc_core
// Config registers, debounce and gesture state, per-tick classification.
// ----------------------------------------------------------------------------
module bcc_core #(
	parameter int TIMER_WIDTH = bcc_pkg::TIMER_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bcc_pkg::IDX_WIDTH-1:0]      cfg_index,
	input  logic [bcc_pkg::CFG_WIDTH-1:0]      cfg_data,
	input  logic                               step,
	input  logic                               level,
	output bcc_pkg::result_t                   result
);

	localparam int CW = (TIMER_WIDTH > bcc_pkg::CFG_WIDTH) ? TIMER_WIDTH : bcc_pkg::CFG_WIDTH;
	localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

	logic [bcc_pkg::CFG_WIDTH-1:0] debounce_q, gap_q, long_q;
	logic                          raw_prev_q, acc_q, press_q;
	logic [TIMER_WIDTH-1:0]        edge_t_q, press_t_q, rel_t_q;
	bcc_pkg::gesture_t             pend_q;

	logic [TIMER_WIDTH-1:0] edge_adv, press_adv, rel_adv;
	logic [TIMER_WIDTH-1:0] edge_nx, press_nx, rel_nx;
	logic                   acc_nx, press_rec_nx, edge_hit, bounce;
	bcc_pkg::gesture_t      pend_mid, pend_nx, report;
	logic [CW-1:0]          deb_w, gap_w, long_w, edge_w, press_w, rel_w, rel_nx_w;

	function automatic logic [TIMER_WIDTH-1:0] advance(input logic [TIMER_WIDTH-1:0] t);
		advance = (t == TMAX) ? TMAX : t + TIMER_WIDTH'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= bcc_pkg::DEBOUNCE_RST;
			gap_q      <= bcc_pkg::GAP_RST;
			long_q     <= bcc_pkg::LONG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bcc_pkg::REG_DEBOUNCE: debounce_q <= cfg_data;
				bcc_pkg::REG_GAP:      gap_q      <= cfg_data;
				bcc_pkg::REG_LONG:     long_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		edge_adv  = advance(edge_t_q);
		press_adv = advance(press_t_q);
		rel_adv   = advance(rel_t_q);
		deb_w     = CW'(debounce_q);
		gap_w     = CW'(gap_q);
		long_w    = CW'(long_q);
		edge_w    = CW'(edge_adv);
		press_w   = CW'(press_adv);
		rel_w     = CW'(rel_adv);

		edge_nx      = edge_adv;
		press_nx     = press_adv;
		rel_nx       = rel_adv;
		acc_nx       = acc_q;
		press_rec_nx = press_q;
		pend_mid     = pend_q;

		edge_hit = (level != raw_prev_q) && (level != acc_q);
		bounce   = edge_w <= deb_w;
		if (edge_hit) begin
			edge_nx = '0;
			if (!bounce) begin
				acc_nx = level;
				if (!level) begin
					press_rec_nx = 1'b1;
					press_nx     = '0;
				end else if (press_q) begin
					if (press_w >= long_w) begin
						pend_mid = bcc_pkg::G_LONG;
					end else if (rel_w < gap_w) begin
						pend_mid = bcc_pkg::G_DOUBLE;
					end else begin
						pend_mid = bcc_pkg::G_SINGLE;
					end
					rel_nx       = '0;
					press_rec_nx = 1'b0;
				end
			end
		end

		rel_nx_w = CW'(rel_nx);
		report   = bcc_pkg::G_NONE;
		pend_nx  = pend_mid;
		if ((rel_nx_w > gap_w) && (pend_mid != bcc_pkg::G_NONE)) begin
			report  = pend_mid;
			pend_nx = bcc_pkg::G_NONE;
		end

		result.gesture      = report;
		result.stable_level = acc_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_prev_q <= 1'b0;
			acc_q      <= 1'b0;
			press_q    <= 1'b0;
			edge_t_q   <= '0;
			press_t_q  <= '0;
			rel_t_q    <= '0;
			pend_q     <= bcc_pkg::G_NONE;
		end else if (step) begin
			raw_prev_q <= level;
			acc_q      <= acc_nx;
			press_q    <= press_rec_nx;
			edge_t_q   <= edge_nx;
			press_t_q  <= press_nx;
			rel_t_q    <= rel_nx;
			pend_q     <= pend_nx;
		end
	end

endmodule

// File: rtl/bcc_out.sv
// ----------------------------------------------------------------------------
// bcc_out
// Result register feeding the master-side stream.
// ----------------------------------------------------------------------------
module bcc_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  bcc_pkg::result_t result,
	output logic             can_load,
	output logic             out_valid,
	input  logic             out_ready,
	output bcc_pkg::result_t result_s2
);

	assign can_load = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (can_load) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			result_s2 <= result;
		end
	end

endmodule

// File: rtl/button_click_classifier.sv
// ----------------------------------------------------------------------------
// button_click_classifier
// Debounces a raw active-low button level per tick and reports single,
// double and long presses once the gap time has passed.
// Path: the input reg holds each accepted level, then the result reg captures its result.
// Throughput: one item per cycle while the output side is ready.
// Reset: arst_n clears state and restores register defaults 50/250/4000.
// ----------------------------------------------------------------------------
module button_click_classifier #(
	parameter int TIMER_WIDTH = bcc_pkg::TIMER_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bcc_pkg::IDX_WIDTH-1:0] cfg_index,
	input  logic [bcc_pkg::CFG_WIDTH-1:0] cfg_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [0] pin_level
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [7:0]                    m_axis_tdata   // [1:0] gesture, [2] stable_level
);

	logic             valid_s1, level_s1, can_load, take;
	bcc_pkg::result_t result, result_s2;

	assign take = valid_s1 && can_load;

	bcc_in u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_level (s_axis_tdata[0]),
		.take     (take),
		.valid_s1 (valid_s1),
		.level_s1 (level_s1)
	);

	bcc_core #(.TIMER_WIDTH(TIMER_WIDTH)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (take),
		.level     (level_s1),
		.result    (result)
	);

	bcc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.result    (result),
		.can_load  (can_load),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.result_s2 (result_s2)
	);

	assign m_axis_tdata = {5'b0, result_s2.stable_level, result_s2.gesture};

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for button_click_classifier. Each accepted tick is
// run through a local debounce and gesture predictor. Each accepted result is
// checked field by field against the oldest prediction. Both stream sides
// idle at random, and there is one long output hold-off. Thresholds are
// rewritten between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb;

	localparam int                            SETTLE     = 8;
	localparam int                            LIMIT      = 400000;
	localparam logic [bcc_pkg::IDX_WIDTH-1:0] REG_UNUSED = 2'd3;

	logic                          clk           = 1'b0;
	logic                          arst_n        = 1'b0;
	logic                          cfg_we        = 1'b0;
	logic [bcc_pkg::IDX_WIDTH-1:0] cfg_index     = '0;
	logic [bcc_pkg::CFG_WIDTH-1:0] cfg_data      = '0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [7:0]                    s_axis_tdata  = '0;  // [0] pin_level
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [7:0]                    m_axis_tdata;        // [1:0] gesture, [2] stable_level

	button_click_classifier i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [bcc_pkg::CFG_WIDTH-1:0]   cfg_debounce = bcc_pkg::DEBOUNCE_RST;
	logic [bcc_pkg::CFG_WIDTH-1:0]   cfg_gap      = bcc_pkg::GAP_RST;
	logic [bcc_pkg::CFG_WIDTH-1:0]   cfg_long     = bcc_pkg::LONG_RST;
	logic                            last_raw     = 1'b0;
	logic                            debounced    = 1'b0;
	logic                            pressed_seen = 1'b0;
	logic [bcc_pkg::TIMER_WIDTH-1:0] edge_age     = '0;
	logic [bcc_pkg::TIMER_WIDTH-1:0] hold_age     = '0;
	logic [bcc_pkg::TIMER_WIDTH-1:0] release_age  = '0;
	bcc_pkg::gesture_t               queued       = bcc_pkg::G_NONE;

	logic             levels_to_send[$];
	bcc_pkg::result_t reports_due[$];

	int failures      = 0;
	int ticks_sent    = 0;
	int results_seen  = 0;
	int settings_run  = 0;
	int n_single      = 0;
	int n_double      = 0;
	int n_long        = 0;
	int cycles        = 0;

	function automatic logic [bcc_pkg::TIMER_WIDTH-1:0] bump(
			input logic [bcc_pkg::TIMER_WIDTH-1:0] t);
		return (t == '1) ? t : t + (bcc_pkg::TIMER_WIDTH)'(1);
	endfunction

	// counters advance first, then the edge, then the report check
	function automatic bcc_pkg::result_t classify_tick(input logic lvl);
		bcc_pkg::result_t r;
		logic             bounce;
		edge_age    = bump(edge_age);
		hold_age    = bump(hold_age);
		release_age = bump(release_age);
		r.gesture   = bcc_pkg::G_NONE;
		if (lvl != last_raw && lvl != debounced) begin
			bounce   = (edge_age <= cfg_debounce);
			edge_age = '0;
			if (!bounce) begin
				debounced = lvl;
				if (!lvl) begin
					pressed_seen = 1'b1;
					hold_age     = '0;
				end else if (pressed_seen) begin
					if (hold_age >= cfg_long)
						queued = bcc_pkg::G_LONG;
					else if (release_age < cfg_gap)
						queued = bcc_pkg::G_DOUBLE;
					else
						queued = bcc_pkg::G_SINGLE;
					release_age  = '0;
					pressed_seen = 1'b0;
				end
			end
		end
		last_raw = lvl;
		if (release_age > cfg_gap && queued != bcc_pkg::G_NONE) begin
			r.gesture = queued;
			queued    = bcc_pkg::G_NONE;
		end
		r.stable_level = debounced;
		return r;
	endfunction

	// sender: bursts of random length, random idle gaps between them
	int burst_left = 0;
	int idle_left  = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				reports_due.push_back(classify_tick(s_axis_tdata[0]));
				ticks_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (idle_left != 0) begin
					idle_left--;
					s_axis_tvalid <= 1'b0;
				end else if (levels_to_send.size() != 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {7'd0, levels_to_send.pop_front()};
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall mode redrawn at random each time mode_age wraps, plus one long hold-off
	int   stall_mode   = 0;
	int   mode_age     = 0;
	int   holdoff_left = 0;
	bit   holdoff_done = 1'b0;
	logic [15:0] stall_bits = 16'hffff;

	always @(posedge clk) begin
		bcc_pkg::result_t want;
		bcc_pkg::result_t got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.gesture      = bcc_pkg::gesture_t'(m_axis_tdata[1:0]);
				got.stable_level = m_axis_tdata[2];
				results_seen++;
				case (got.gesture)
					bcc_pkg::G_SINGLE: n_single++;
					bcc_pkg::G_DOUBLE: n_double++;
					bcc_pkg::G_LONG:   n_long++;
					default: ;
				endcase
				if (reports_due.size() == 0) begin
					$error("result with no prediction waiting: tdata %h", m_axis_tdata);
					failures++;
				end else begin
					want = reports_due.pop_front();
					if (got.gesture != want.gesture) begin
						$error("gesture mismatch: expected %0d, got %0d",
							want.gesture, got.gesture);
						failures++;
					end
					if (got.stable_level != want.stable_level) begin
						$error("stable_level mismatch: expected %0d, got %0d",
							want.stable_level, got.stable_level);
						failures++;
					end
				end
			end
			if (results_seen == 400 && !holdoff_done) begin
				holdoff_done = 1'b1;
				holdoff_left = 300;
			end
			if (mode_age == 31) begin
				mode_age   = 0;
				stall_mode = $urandom_range(0, 3);
				stall_bits = 16'($urandom_range(0, 16'hffff));
			end else begin
				mode_age++;
			end
			if (holdoff_left != 0) begin
				holdoff_left--;
				m_axis_tready <= 1'b0;
			end else begin
				case (stall_mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 1) == 1);
					2: m_axis_tready <= stall_bits[4'(mode_age)];
					default: m_axis_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles, %0d predictions outstanding",
				cycles, reports_due.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic set_reg(input logic [bcc_pkg::IDX_WIDTH-1:0] idx,
			input logic [bcc_pkg::CFG_WIDTH-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			bcc_pkg::REG_DEBOUNCE: cfg_debounce = val;
			bcc_pkg::REG_GAP:      cfg_gap      = val;
			bcc_pkg::REG_LONG:     cfg_long     = val;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [bcc_pkg::CFG_WIDTH-1:0] deb,
			input logic [bcc_pkg::CFG_WIDTH-1:0] gap,
			input logic [bcc_pkg::CFG_WIDTH-1:0] lng);
		set_reg(bcc_pkg::REG_DEBOUNCE, deb);
		set_reg(REG_UNUSED, (bcc_pkg::CFG_WIDTH)'($urandom_range(0, 16'hffff)));
		set_reg(bcc_pkg::REG_GAP, gap);
		set_reg(bcc_pkg::REG_LONG, lng);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	// press/release pairs of random length, mixed with short chatter
	task automatic queue_gestures(input int count, input int hold_max, input int rest_max);
		int n;
		int len;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 9) < 2) begin
				len = $urandom_range(1, 6);
				repeat (len) levels_to_send.push_back($urandom_range(0, 1) == 1);
				n += len;
			end else begin
				len = $urandom_range(1, hold_max);
				repeat (len) levels_to_send.push_back(1'b0);
				n += len;
				len = $urandom_range(1, rest_max);
				repeat (len) levels_to_send.push_back(1'b1);
				n += len;
			end
		end
	endtask

	task automatic drain();
		while (levels_to_send.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (reports_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_phase(input logic [bcc_pkg::CFG_WIDTH-1:0] deb,
			input logic [bcc_pkg::CFG_WIDTH-1:0] gap,
			input logic [bcc_pkg::CFG_WIDTH-1:0] lng, input int count, input int hold_max,
			input int rest_max);
		configure(deb, gap, lng);
		queue_gestures(count, hold_max, rest_max);
		drain();
	endtask

	// release without press, double right after reset, long, overwrite, single
	logic directed_levels[26] = '{
		1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
		1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
	};

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(16'd0, 16'd4, 16'd3);
		foreach (directed_levels[i]) levels_to_send.push_back(directed_levels[i]);
		drain();

		run_phase(16'd2,     16'd6,     16'd8,     300, 12,  10);
		run_phase(16'd0,     16'd0,     16'd0,     150, 4,   4);
		run_phase(16'hffff,  16'hffff,  16'hffff,  80,  6,   6);
		run_phase(16'd5,     16'd20,    16'd15,    300, 25,  30);
		run_phase(16'd1,     16'd3,     16'hffff,  200, 10,  8);
		run_phase(bcc_pkg::DEBOUNCE_RST, bcc_pkg::GAP_RST, bcc_pkg::LONG_RST, 400, 150, 200);
		run_phase(16'd3,     16'hffff,  16'd2,     120, 8,   8);

		$display("%0d ticks over %0d threshold settings, %0d results checked",
			ticks_sent, settings_run, results_seen);
		$display("reports seen: %0d single, %0d double, %0d long",
			n_single, n_double, n_long);
		if (failures == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: button_click_classifier.f
rtl/bcc_pkg.sv
rtl/bcc_in.sv
rtl/bcc_core.sv
rtl/bcc_out.sv
rtl/button_click_classifier.sv
bench/tb.sv
